@@ hdl/htd_pkg.sv @@
// shared types and constants of the huffman tree decoder
`timescale 1ns / 1ps

package htd_pkg;

	localparam logic [1:0] FUNC_LOAD   = 2'd0;
	localparam logic [1:0] FUNC_START  = 2'd1;
	localparam logic [1:0] FUNC_DECODE = 2'd2;

	localparam int unsigned ROOT_NODE  = 254;
	localparam int unsigned LEAF_LIMIT = 256;

	localparam int unsigned ARG_W     = 26;
	localparam int unsigned CMD_DEPTH = 2;
	localparam int unsigned RES_DEPTH = 4;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_START,
		OP_DECODE
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [ARG_W-1:0] arg;
	} cmd_t;

	typedef struct packed {
		logic [7:0] symbol;
		logic       last_of_item;
		logic       chunk_done;
	} res_t;

endpackage

@@ hdl/htd_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps

module htd_ram #(
	parameter int unsigned WIDTH = 18,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

endmodule

@@ hdl/htd_fifo.sv @@
// small synchronous first-in first-out queue
`timescale 1ns / 1ps

module htd_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

@@ hdl/htd_front.sv @@
// front end: takes input words, sorts them into commands and queues them
`timescale 1ns / 1ps

module htd_front import htd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  func,
	input  logic [7:0]  node_index,
	input  logic [8:0]  child_zero,
	input  logic [8:0]  child_one,
	input  logic [23:0] chunk_length,
	input  logic [7:0]  data_byte,
	input  logic        cmd_pop,
	output cmd_t        cmd,
	output logic        cmd_empty
);

	cmd_t cmd_in;
	logic known;

	always_comb begin
		cmd_in = '{op: OP_LOAD, arg: '0};
		known  = 1'b1;
		case (func)
			FUNC_LOAD: begin
				cmd_in.op  = OP_LOAD;
				cmd_in.arg = {child_one, child_zero, node_index};
			end
			FUNC_START: begin
				cmd_in.op  = OP_START;
				cmd_in.arg = {2'b00, chunk_length};
			end
			FUNC_DECODE: begin
				cmd_in.op  = OP_DECODE;
				cmd_in.arg = {18'd0, data_byte};
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	htd_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push && !full && known),
		.din    (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.dout   (cmd),
		.empty  (cmd_empty)
	);

endmodule

@@ hdl/htd_back.sv @@
// back end: table loads, chunk starts and the bit by bit tree walk
`timescale 1ns / 1ps

module htd_back import htd_pkg::*; #(
	parameter int unsigned TABLE_NODES = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  logic cmd_empty,
	output logic cmd_pop,
	output res_t res,
	output logic res_push,
	input  logic res_full
);

	localparam int unsigned AW = $clog2(TABLE_NODES);
	localparam logic [AW-1:0] ROOT_SLOT = AW'(ROOT_NODE % TABLE_NODES);

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_WALK,
		S_FLUSH
	} state_t;

	state_t        state_q;
	logic [AW-1:0] cur_node_q;
	logic [23:0]   left_q;
	logic [2:0]    bit_q;
	logic [7:0]    data_q;
	logic          pend_valid_q;
	logic [7:0]    pend_sym_q;
	logic          pend_done_q;

	logic [AW-1:0] slot_lut [LEAF_LIMIT];
	logic [17:0]   entry;
	logic [8:0]    path;
	logic          leaf;
	logic          stall;
	logic [23:0]   left_n;
	logic [AW-1:0] next_node;
	logic          ram_we;
	logic [AW-1:0] raddr;

	// node index folded into the table size
	for (genvar g = 0; g < LEAF_LIMIT; g++) begin : g_slot
		assign slot_lut[g] = AW'(g % TABLE_NODES);
	end

	assign path      = data_q[bit_q] ? entry[17:9] : entry[8:0];
	assign leaf      = !path[8];
	assign left_n    = left_q - 24'd1;
	assign next_node = leaf ? ROOT_SLOT : slot_lut[path[7:0]];
	assign stall     = (state_q == S_WALK) && leaf && pend_valid_q && res_full;
	assign raddr     = ((state_q == S_WALK) && !stall) ? next_node : cur_node_q;
	assign ram_we    = (state_q == S_IDLE) && !cmd_empty && (cmd.op == OP_LOAD);
	assign cmd_pop   = (state_q == S_IDLE) && !cmd_empty;

	always_comb begin
		res_push = 1'b0;
		res      = '{symbol: pend_sym_q, last_of_item: 1'b0, chunk_done: pend_done_q};
		case (state_q)
			S_WALK: begin
				res_push = leaf && pend_valid_q && !res_full;
			end
			S_FLUSH: begin
				res_push         = pend_valid_q && !res_full;
				res.last_of_item = 1'b1;
			end
			default: begin
				res_push = 1'b0;
			end
		endcase
	end

	htd_ram #(
		.WIDTH (18),
		.DEPTH (TABLE_NODES)
	) u_table (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (slot_lut[cmd.arg[7:0]]),
		.wdata   (cmd.arg[25:8]),
		.raddr   (raddr),
		.rdata_q (entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cur_node_q   <= ROOT_SLOT;
			left_q       <= '0;
			bit_q        <= '0;
			data_q       <= '0;
			pend_valid_q <= 1'b0;
			pend_sym_q   <= '0;
			pend_done_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (!cmd_empty) begin
						case (cmd.op)
							OP_START: begin
								left_q     <= cmd.arg[23:0];
								cur_node_q <= ROOT_SLOT;
							end
							OP_DECODE: begin
								if (left_q != '0) begin
									data_q  <= cmd.arg[7:0];
									bit_q   <= '0;
									state_q <= S_FETCH;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_FETCH: begin
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (!stall) begin
						cur_node_q <= next_node;
						if (leaf) begin
							left_q       <= left_n;
							pend_valid_q <= 1'b1;
							pend_sym_q   <= path[7:0];
							pend_done_q  <= (left_n == '0);
						end
						if ((leaf && left_n == '0) || bit_q == 3'd7) begin
							state_q <= S_FLUSH;
						end else begin
							bit_q <= bit_q + 3'd1;
						end
					end
				end
				S_FLUSH: begin
					if (!pend_valid_q) begin
						state_q <= S_IDLE;
					end else if (!res_full) begin
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hdl/huffman_tree_decoder_top.sv @@
// top level of the huffman tree decoder
`timescale 1ns / 1ps

// Tree-walking Huffman decoder. Input words are taken into a two-entry
// command queue, so a load, start or decode word can be pushed while the
// walker is still busy; decoded symbols leave through a four-entry result
// queue. A load or start word is handled in the back end's idle state. A
// decode byte passes through dispatch, a fetch step that primes the
// registered read of the node table, one table step per bit for the eight
// bits (fewer if the chunk ends mid byte), and a flush step that releases
// the last symbol with its last_of_item mark. The dependent node-table
// read, one per bit, sets the pace; a full result queue stalls the walk.
// The table holds TABLE_NODES nodes and comes up unwritten: walking into
// a node never loaded gives undefined symbols.
module huffman_tree_decoder_top import htd_pkg::*; #(
	parameter int unsigned TABLE_NODES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  func,
	input  logic [7:0]  node_index,
	input  logic [8:0]  child_zero,
	input  logic [8:0]  child_one,
	input  logic [23:0] chunk_length,
	input  logic [7:0]  data_byte,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  symbol,
	output logic        last_of_item,
	output logic        chunk_done
);

	cmd_t cmd;
	logic cmd_empty;
	logic cmd_pop;
	res_t res_in;
	res_t res_out;
	logic res_push;
	logic res_full;

	htd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.func         (func),
		.node_index   (node_index),
		.child_zero   (child_zero),
		.child_one    (child_one),
		.chunk_length (chunk_length),
		.data_byte    (data_byte),
		.cmd_pop      (cmd_pop),
		.cmd          (cmd),
		.cmd_empty    (cmd_empty)
	);

	htd_back #(
		.TABLE_NODES (TABLE_NODES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res       (res_in),
		.res_push  (res_push),
		.res_full  (res_full)
	);

	htd_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_in),
		.full   (res_full),
		.pop    (pop),
		.dout   (res_out),
		.empty  (empty)
	);

	assign symbol       = res_out.symbol;
	assign last_of_item = res_out.last_of_item;
	assign chunk_done   = res_out.chunk_done;

endmodule

@@ dv/tb_top.sv @@
// self-checking testbench of the huffman tree decoder
`timescale 1ns / 1ps

module tb_top;
	import htd_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int RANDOM_WORDS = 310;
	localparam int IDLE_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  node_index;
		logic [8:0]  child_zero;
		logic [8:0]  child_one;
		logic [23:0] chunk_length;
		logic [7:0]  data_byte;
		logic        typed;
		logic [3:0]  exp_n;
		logic [7:0]  exp_sym;
		logic        exp_done;
	} word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty;
	logic [7:0] symbol;
	logic last_of_item, chunk_done;
	word_t drv = '0;

	// decoder state as seen by the predictor
	logic [17:0] tree_mem [256];
	logic [7:0]  walk_node = 8'(ROOT_NODE);
	logic [23:0] left_count = '0;
	res_t        walk_out [$];
	res_t        expected_symbols [$];
	res_t        want, typed_res;

	// nodes written so far, so that no walk reaches an unwritten node
	bit          loaded [256];
	logic [7:0]  loaded_list [$];

	int errors = 0;
	int idle_cycles = 0;
	int words_sent = 0;
	int burst_left = 4;
	int stall_left = 0;
	logic [9:0] rx_phase = '0;
	word_t rows [$];

	huffman_tree_decoder_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.func         (drv.func),
		.node_index   (drv.node_index),
		.child_zero   (drv.child_zero),
		.child_one    (drv.child_one),
		.chunk_length (drv.chunk_length),
		.data_byte    (drv.data_byte),
		.empty        (empty),
		.pop          (pop),
		.symbol       (symbol),
		.last_of_item (last_of_item),
		.chunk_done   (chunk_done)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void walk_tree(input word_t w);
		logic [17:0] entry;
		logic [8:0]  path;
		res_t        r;
		walk_out.delete();
		case (w.func)
			FUNC_LOAD: tree_mem[w.node_index] = {w.child_one, w.child_zero};
			FUNC_START: begin
				left_count = w.chunk_length;
				walk_node = 8'(ROOT_NODE);
			end
			FUNC_DECODE: begin
				if (left_count != 0) begin
					for (int b = 0; b < 8; b++) begin
						entry = tree_mem[walk_node];
						path = w.data_byte[b] ? entry[17:9] : entry[8:0];
						if (path < LEAF_LIMIT) begin
							left_count = left_count - 24'd1;
							r.symbol = path[7:0];
							r.last_of_item = 1'b0;
							r.chunk_done = (left_count == 0);
							walk_out.push_back(r);
							walk_node = 8'(ROOT_NODE);
							if (left_count == 0)
								break;
						end else begin
							walk_node = path[7:0];
						end
					end
					if (walk_out.size() > 0) begin
						r = walk_out.pop_back();
						r.last_of_item = 1'b1;
						walk_out.push_back(r);
					end
				end
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_symbols.size() == 0) begin
					$error("unexpected symbol %0h", symbol);
					errors++;
				end else begin
					want = expected_symbols.pop_front();
					if (symbol !== want.symbol) begin
						$error("symbol: expected %0h, got %0h", want.symbol, symbol);
						errors++;
					end
					if (last_of_item !== want.last_of_item) begin
						$error("last_of_item: expected %0b, got %0b",
							want.last_of_item, last_of_item);
						errors++;
					end
					if (chunk_done !== want.chunk_done) begin
						$error("chunk_done: expected %0b, got %0b",
							want.chunk_done, chunk_done);
						errors++;
					end
				end
			end
			if (push && !full) begin
				walk_tree(drv);
				if (drv.typed) begin
					for (int k = 0; k < int'(drv.exp_n); k++) begin
						typed_res.symbol = drv.exp_sym;
						typed_res.last_of_item = (k == int'(drv.exp_n) - 1);
						typed_res.chunk_done = typed_res.last_of_item && drv.exp_done;
						expected_symbols.push_back(typed_res);
					end
				end else begin
					foreach (walk_out[i])
						expected_symbols.push_back(walk_out[i]);
				end
			end
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	// receiver: free-running half the time, random stalls the other half
	always @(negedge clk) begin
		rx_phase <= rx_phase + 10'd1;
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			pop <= 1'b0;
		end else if (rx_phase[8] && $urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 19);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	function automatic void note_loaded(input logic [7:0] idx);
		if (!loaded[idx]) begin
			loaded[idx] = 1'b1;
			loaded_list.push_back(idx);
		end
	endfunction

	function automatic word_t row(input logic [1:0] f, input logic [7:0] idx,
		input logic [8:0] cz, input logic [8:0] co, input logic [23:0] len,
		input logic [7:0] dat, input logic t, input logic [3:0] n,
		input logic [7:0] sym, input logic done);
		word_t w;
		w.func = f;
		w.node_index = idx;
		w.child_zero = cz;
		w.child_one = co;
		w.chunk_length = len;
		w.data_byte = dat;
		w.typed = t;
		w.exp_n = n;
		w.exp_sym = sym;
		w.exp_done = done;
		return w;
	endfunction

	function automatic word_t rand_word(input logic [1:0] f);
		return row(f, 8'($urandom), 9'($urandom), 9'($urandom), 24'($urandom),
			8'($urandom), 1'b0, 4'd0, 8'd0, 1'b0);
	endfunction

	function automatic logic [8:0] pick_child();
		if ($urandom_range(0, 1) == 0)
			return {1'b0, 8'($urandom)};
		return {1'b1, loaded_list[$urandom_range(0, loaded_list.size() - 1)]};
	endfunction

	task automatic send_word(input word_t w);
		if (w.func == FUNC_LOAD)
			note_loaded(w.node_index);
		push <= 1'b1;
		drv <= w;
		@(posedge clk);
		while (full)
			@(posedge clk);
		@(negedge clk);
		if (w.func != FUNC_UNUSED)
			words_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 12))
				@(negedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 16);
		end
	endtask

	task automatic drain();
		push <= 1'b0;
		@(negedge clk);
		while (expected_symbols.size() != 0)
			@(negedge clk);
	endtask

	task automatic random_traffic();
		word_t w;
		int kind;
		bit paused;
		paused = 1'b0;
		words_sent = 0;
		while (words_sent < RANDOM_WORDS) begin
			if (!paused && words_sent >= RANDOM_WORDS / 2) begin
				drain();
				paused = 1'b1;
			end
			kind = $urandom_range(0, 9);
			if (kind <= 1 || kind == 9) begin
				// tree edit, sometimes in the middle of a chunk
				repeat ($urandom_range(1, 4)) begin
					w = rand_word(FUNC_LOAD);
					if ($urandom_range(0, 3) == 0)
						w.node_index = 8'(ROOT_NODE);
					note_loaded(w.node_index);
					w.child_zero = pick_child();
					w.child_one = pick_child();
					send_word(w);
				end
				if (kind == 9)
					repeat ($urandom_range(1, 3))
						send_word(rand_word(FUNC_DECODE));
			end else if (kind <= 7) begin
				w = rand_word(FUNC_START);
				case ($urandom_range(0, 9))
					0: w.chunk_length = '0;
					1: ;
					default: w.chunk_length = 24'($urandom_range(1, 40));
				endcase
				send_word(w);
				repeat ($urandom_range(1, 8))
					send_word(rand_word(FUNC_DECODE));
			end else begin
				send_word(rand_word(($urandom_range(0, 1) == 0) ? FUNC_UNUSED
					: FUNC_DECODE));
			end
		end
	endtask

	initial begin
		repeat (5)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		rows.push_back(row(FUNC_DECODE, 8'h00, 9'h000, 9'h000, 24'd0, 8'hA5, 1, 0, 8'h00, 0));
		rows.push_back(row(FUNC_UNUSED, 8'hFF, 9'h1FF, 9'h1FF, 24'hFFFFFF, 8'hFF,
			1, 0, 8'h00, 0));
		rows.push_back(row(FUNC_LOAD, 8'd254, 9'h000, 9'h0FF, 24'd0, 8'h00, 1, 0, 8'h00, 0));
		rows.push_back(row(FUNC_START, 8'h00, 9'h000, 9'h000, 24'd0, 8'h00, 1, 0, 8'h00, 0));
		rows.push_back(row(FUNC_DECODE, 8'h00, 9'h000, 9'h000, 24'd0, 8'hFF, 1, 0, 8'h00, 0));
		rows.push_back(row(FUNC_START, 8'h00, 9'h000, 9'h000, 24'd3, 8'h00, 1, 0, 8'h00, 0));
		rows.push_back(row(FUNC_DECODE, 8'h00, 9'h000, 9'h000, 24'd0, 8'h00, 1, 3, 8'h00, 1));
		rows.push_back(row(FUNC_DECODE, 8'h00, 9'h000, 9'h000, 24'd0, 8'h00, 1, 0, 8'h00, 0));
		rows.push_back(row(FUNC_START, 8'h00, 9'h000, 9'h000, 24'hFFFFFF, 8'h00,
			1, 0, 8'h00, 0));
		rows.push_back(row(FUNC_DECODE, 8'h00, 9'h000, 9'h000, 24'd0, 8'hFF, 1, 8, 8'hFF, 0));
		rows.push_back(row(FUNC_LOAD, 8'd255, 9'h055, 9'h1FE, 24'd0, 8'h00, 1, 0, 8'h00, 0));
		rows.push_back(row(FUNC_LOAD, 8'd0, 9'h1FF, 9'h0AA, 24'd0, 8'h00, 1, 0, 8'h00, 0));
		rows.push_back(row(FUNC_LOAD, 8'd254, 9'h100, 9'h1FE, 24'd0, 8'h00, 1, 0, 8'h00, 0));
		rows.push_back(row(FUNC_START, 8'h00, 9'h000, 9'h000, 24'd1, 8'h00, 0, 0, 8'h00, 0));
		rows.push_back(row(FUNC_DECODE, 8'h00, 9'h000, 9'h000, 24'd0, 8'h00, 0, 0, 8'h00, 0));
		rows.push_back(row(FUNC_START, 8'h00, 9'h000, 9'h000, 24'd20, 8'h00, 0, 0, 8'h00, 0));
		rows.push_back(row(FUNC_DECODE, 8'h00, 9'h000, 9'h000, 24'd0, 8'hA5, 0, 0, 8'h00, 0));
		rows.push_back(row(FUNC_DECODE, 8'h00, 9'h000, 9'h000, 24'd0, 8'h3C, 0, 0, 8'h00, 0));
		rows.push_back(row(FUNC_DECODE, 8'h00, 9'h000, 9'h000, 24'd0, 8'hFF, 0, 0, 8'h00, 0));
		rows.push_back(row(FUNC_DECODE, 8'h00, 9'h000, 9'h000, 24'd0, 8'h01, 0, 0, 8'h00, 0));
		// restart while the walker sits on an inner node
		rows.push_back(row(FUNC_START, 8'h00, 9'h000, 9'h000, 24'd2, 8'h00, 0, 0, 8'h00, 0));
		rows.push_back(row(FUNC_LOAD, 8'd128, 9'h180, 9'h0FF, 24'd0, 8'h00, 0, 0, 8'h00, 0));
		rows.push_back(row(FUNC_LOAD, 8'd254, 9'h180, 9'h000, 24'd0, 8'h00, 0, 0, 8'h00, 0));
		rows.push_back(row(FUNC_DECODE, 8'h00, 9'h000, 9'h000, 24'd0, 8'h5A, 0, 0, 8'h00, 0));
		rows.push_back(row(FUNC_DECODE, 8'h00, 9'h000, 9'h000, 24'd0, 8'h00, 0, 0, 8'h00, 0));

		foreach (rows[i])
			send_word(rows[i]);
		drain();

		random_traffic();
		drain();
		repeat (SETTLE_CYCLES)
			@(negedge clk);
		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

@@ files.f @@
hdl/htd_pkg.sv
hdl/htd_ram.sv
hdl/htd_fifo.sv
hdl/htd_front.sv
hdl/htd_back.sv
hdl/huffman_tree_decoder_top.sv
dv/tb_top.sv
